FILE: rtl/pafp_pkg.sv
// Shared widths, constants and types of the pointing-angle pipeline.
package pafp_pkg;

    // Input coordinate format and pipeline depth.
    localparam int COORD_WIDTH   = 24;
    localparam int CORDIC_STAGES = 16;

    // Differences carry one extra bit; the guard shift brings them up to 41 bits.
    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int GUARD  = 40 - COORD_WIDTH;

    // CORDIC vector width: 41-bit operands plus headroom for gain and two passes.
    localparam int CW = 46;
    // Angle accumulator in degrees, Q.24, wide enough for the 180-degree offset.
    localparam int ZW = 34;

    // CORDIC gain in Q.20, applied to dz so that it matches the horizontal magnitude.
    localparam int GAIN_W = 21;
    localparam int GAIN_FRAC = 20;
    localparam logic [GAIN_W-1:0] GAIN_Q20 = 21'd1726753;
    localparam int PROD_W = DIFF_W + GAIN_W;

    // Output angle formats.
    localparam int Q8_W    = ZW - 16;
    localparam int PITCH_W = 16;
    localparam int YAW_W   = 18;
    localparam logic signed [ZW-1:0]   DEG180_Q24 = 34'sd3019898880;
    localparam logic signed [Q8_W-1:0] DEG90_Q8   = 18'sd23040;
    localparam logic signed [Q8_W-1:0] DEG270_Q8  = 18'sd69120;

    // Stream widths, padded to whole bytes.
    localparam int S_TDATA_W = ((6 * COORD_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W = ((PITCH_W + YAW_W + 7) / 8) * 8;

    // Front end, two CORDIC passes and the rounding stage.
    localparam int LAT = 3 + 2 * CORDIC_STAGES + 1;

    // Per-item decisions made in the front end and used at the output.
    typedef struct packed {
        logic degen;
        logic dx_zero;
        logic dx_pos;
        logic dy_pos;
        logic dz_pos;
        logic dz_neg;
    } flags_t;

    // One finished result.
    typedef struct packed {
        logic signed [PITCH_W-1:0] pitch;
        logic signed [YAW_W-1:0]   yaw;
        logic                      degen;
    } result_t;

endpackage

FILE: rtl/pafp_front.sv
// Front end: coordinate differences, magnitudes and gain-scaled dz over three stages.
module pafp_front import pafp_pkg::*; (
    input  logic                          aclk,
    input  logic                          en,
    input  logic signed [COORD_WIDTH-1:0] src_x,
    input  logic signed [COORD_WIDTH-1:0] src_y,
    input  logic signed [COORD_WIDTH-1:0] src_z,
    input  logic signed [COORD_WIDTH-1:0] dst_x,
    input  logic signed [COORD_WIDTH-1:0] dst_y,
    input  logic signed [COORD_WIDTH-1:0] dst_z,
    output logic signed [CW-1:0]          yaw_x,
    output logic signed [CW-1:0]          yaw_y,
    output logic signed [CW-1:0]          hor_x,
    output logic signed [CW-1:0]          hor_y,
    output logic signed [CW-1:0]          dzk,
    output flags_t                        flags
);

    logic signed [DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic [DIFF_W-1:0]        ax_reg, ay_reg, adz_reg;
    logic signed [DIFF_W-1:0] yv_reg;
    flags_t                   flags_s2_reg;

    logic signed [CW-1:0] yaw_x_reg, yaw_y_reg, hor_x_reg, hor_y_reg, dzk_reg;
    flags_t               flags_s3_reg;

    logic [PROD_W-1:0]       prod;
    logic [PROD_W+GUARD-1:0] scaled;
    logic signed [CW-1:0]    mz;

    // Stage 1: difference source minus target.
    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg <= DIFF_W'(src_x) - DIFF_W'(dst_x);
            dy_reg <= DIFF_W'(src_y) - DIFF_W'(dst_y);
            dz_reg <= DIFF_W'(src_z) - DIFF_W'(dst_z);
        end
    end

    // Stage 2: magnitudes, signs and the special-case flags.
    always_ff @(posedge aclk) begin
        if (en) begin
            ax_reg  <= (dx_reg < 0) ? DIFF_W'(-dx_reg) : DIFF_W'(dx_reg);
            ay_reg  <= (dy_reg < 0) ? DIFF_W'(-dy_reg) : DIFF_W'(dy_reg);
            adz_reg <= (dz_reg < 0) ? DIFF_W'(-dz_reg) : DIFF_W'(dz_reg);
            yv_reg  <= (dx_reg > 0) ? dy_reg : -dy_reg;
            flags_s2_reg.degen   <= (dx_reg == 0) && (dy_reg == 0);
            flags_s2_reg.dx_zero <= (dx_reg == 0);
            flags_s2_reg.dx_pos  <= (dx_reg > 0);
            flags_s2_reg.dy_pos  <= (dy_reg > 0);
            flags_s2_reg.dz_pos  <= (dz_reg > 0);
            flags_s2_reg.dz_neg  <= (dz_reg < 0);
        end
    end

    // The gain product works on |dz| before the guard shift, which only adds zeros.
    assign prod   = PROD_W'(adz_reg) * PROD_W'(GAIN_Q20);
    assign scaled = {prod, {GUARD{1'b0}}} >> GAIN_FRAC;
    assign mz     = CW'(scaled);

    // Stage 3: CORDIC start vectors and signed, gain-scaled dz.
    always_ff @(posedge aclk) begin
        if (en) begin
            yaw_x_reg    <= CW'({ax_reg, {GUARD{1'b0}}});
            yaw_y_reg    <= CW'(yv_reg) <<< GUARD;
            hor_x_reg    <= CW'({ax_reg, {GUARD{1'b0}}});
            hor_y_reg    <= CW'({ay_reg, {GUARD{1'b0}}});
            dzk_reg      <= flags_s2_reg.dz_neg ? -mz : mz;
            flags_s3_reg <= flags_s2_reg;
        end
    end

    assign yaw_x = yaw_x_reg;
    assign yaw_y = yaw_y_reg;
    assign hor_x = hor_x_reg;
    assign hor_y = hor_y_reg;
    assign dzk   = dzk_reg;
    assign flags = flags_s3_reg;

endmodule

FILE: rtl/pafp_cordic.sv
// Vectoring CORDIC, one registered micro-rotation per stage, angle in degrees Q.24.
module pafp_cordic import pafp_pkg::*; (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [CW-1:0] x_in,
    input  logic signed [CW-1:0] y_in,
    output logic signed [CW-1:0] x_out,
    output logic signed [ZW-1:0] z_out
);

    // atan(2^-i) in degrees, Q.24.
    function automatic logic signed [ZW-1:0] atan_deg(input int i);
        logic signed [ZW-1:0] r;
        case (i)
            0:       r = 34'sd754974720;
            1:       r = 34'sd445687602;
            2:       r = 34'sd235489089;
            3:       r = 34'sd119537938;
            4:       r = 34'sd60000934;
            5:       r = 34'sd30029717;
            6:       r = 34'sd15018524;
            7:       r = 34'sd7509720;
            8:       r = 34'sd3754917;
            9:       r = 34'sd1877466;
            10:      r = 34'sd938734;
            11:      r = 34'sd469367;
            12:      r = 34'sd234683;
            13:      r = 34'sd117342;
            14:      r = 34'sd58671;
            15:      r = 34'sd29335;
            16:      r = 34'sd14668;
            17:      r = 34'sd7334;
            18:      r = 34'sd3667;
            19:      r = 34'sd1833;
            20:      r = 34'sd917;
            21:      r = 34'sd458;
            22:      r = 34'sd229;
            23:      r = 34'sd115;
            default: r = '0;
        endcase
        return r;
    endfunction

    logic signed [CW-1:0] x_reg [CORDIC_STAGES];
    logic signed [CW-1:0] y_reg [CORDIC_STAGES];
    logic signed [ZW-1:0] z_reg [CORDIC_STAGES];
    logic signed [CW-1:0] x_next [CORDIC_STAGES];
    logic signed [CW-1:0] y_next [CORDIC_STAGES];
    logic signed [ZW-1:0] z_next [CORDIC_STAGES];

    logic signed [CW-1:0] cx, cy, sx, sy;
    logic signed [ZW-1:0] cz;

    // Each stage rotates toward the x axis; a zero residue rotates as a negative one.
    always_comb begin
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            if (i == 0) begin
                cx = x_in;
                cy = y_in;
                cz = '0;
            end else begin
                cx = x_reg[i-1];
                cy = y_reg[i-1];
                cz = z_reg[i-1];
            end
            sx = cx >>> i;
            sy = cy >>> i;
            if (cy > 0) begin
                x_next[i] = cx + sy;
                y_next[i] = cy - sx;
                z_next[i] = cz + atan_deg(i);
            end else begin
                x_next[i] = cx - sy;
                y_next[i] = cy + sx;
                z_next[i] = cz - atan_deg(i);
            end
        end
    end

    // Stage registers advance together.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < CORDIC_STAGES; i++) begin
                x_reg[i] <= x_next[i];
                y_reg[i] <= y_next[i];
                z_reg[i] <= z_next[i];
            end
        end
    end

    assign x_out = x_reg[CORDIC_STAGES-1];
    assign z_out = z_reg[CORDIC_STAGES-1];

endmodule

FILE: rtl/pafp_out_buf.sv
// Two-entry output buffer that decouples the pipeline from the result channel.
module pafp_out_buf import pafp_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_data
);

    logic [1:0] count_reg;
    result_t    head_reg, tail_reg;
    logic       pop;

    assign pop = m_valid && m_ready;

    // Occupancy; a push never arrives while full.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    // Entry storage: the head is always the next transfer.
    always_ff @(posedge aclk) begin
        if (pop) begin
            head_reg <= (count_reg == 2'd2) ? tail_reg : push_data;
        end else if (push && (count_reg == 2'd0)) begin
            head_reg <= push_data;
        end
        if (push && !pop && (count_reg == 2'd1)) begin
            tail_reg <= push_data;
        end
    end

    assign full    = (count_reg == 2'd2);
    assign m_valid = (count_reg != 2'd0);
    assign m_data  = head_reg;

endmodule

FILE: rtl/pointing_angles_from_points_top.sv
// Pointing angles: top level joining the front end, three CORDIC instances and output buffer.
//
// Takes a source and a target point (signed Q15.8) and returns pitch and yaw of
// source minus target in degrees, signed Q.8, plus a flag for a zero horizontal
// difference. One pair of points is accepted every cycle while the output buffer
// has room. A result passes three front-end stages, sixteen CORDIC stages for yaw
// and the horizontal magnitude in parallel, sixteen more for pitch, and one
// rounding stage into the output buffer; it is offered on m_tvalid from the next cycle.
// The whole pipeline holds while the two-entry output buffer is full, so s_tready
// drops only after two results wait untaken. s_tready comes from registers only.
module pointing_angles_from_points_top import pafp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // src_x, src_y, src_z, dst_x, dst_y, dst_z from the lowest bit up.
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // pitch_deg [15:0], yaw_deg [33:16], zero padding above.
    output logic [M_TDATA_W-1:0] m_tdata,
    // degenerate.
    output logic                 m_tuser
);

    logic adv, full, accept;

    logic signed [CW-1:0] yaw_x, yaw_y, hor_x, hor_y, dzk;
    flags_t               flags;
    logic signed [CW-1:0] hmag, pitch_x_unused;
    logic signed [ZW-1:0] yaw_z, pitch_z;

    logic                 valid_reg     [LAT];
    flags_t               flags_dly_reg [2*CORDIC_STAGES];
    logic signed [CW-1:0] dzk_dly_reg   [CORDIC_STAGES];
    logic signed [ZW-1:0] yawz_dly_reg  [CORDIC_STAGES];
    result_t              res_reg;

    result_t                res_next, ob_data;
    logic                   ob_valid;
    flags_t                 fl;
    logic signed [ZW-1:0]   yaw_a;
    logic signed [Q8_W-1:0] yaw_q8, pitch_q8;

    // Round Q.24 degrees to Q.8 to nearest, ties upward, then clamp.
    function automatic logic signed [Q8_W-1:0] to_q8(
        input logic signed [ZW-1:0]   a,
        input logic signed [Q8_W-1:0] lo,
        input logic signed [Q8_W-1:0] hi
    );
        logic signed [ZW-1:0]   t;
        logic signed [Q8_W-1:0] r;
        t = a + ZW'(32768);
        r = t[ZW-1:16];
        if (r < lo) begin
            r = lo;
        end else if (r > hi) begin
            r = hi;
        end
        return r;
    endfunction

    // The pipeline moves whenever the output buffer has room.
    assign adv      = !full;
    assign s_tready = adv;
    assign accept   = s_tvalid && adv;

    pafp_front u_front (
        .aclk  (aclk),
        .en    (adv),
        .src_x (s_tdata[0*COORD_WIDTH +: COORD_WIDTH]),
        .src_y (s_tdata[1*COORD_WIDTH +: COORD_WIDTH]),
        .src_z (s_tdata[2*COORD_WIDTH +: COORD_WIDTH]),
        .dst_x (s_tdata[3*COORD_WIDTH +: COORD_WIDTH]),
        .dst_y (s_tdata[4*COORD_WIDTH +: COORD_WIDTH]),
        .dst_z (s_tdata[5*COORD_WIDTH +: COORD_WIDTH]),
        .yaw_x (yaw_x),
        .yaw_y (yaw_y),
        .hor_x (hor_x),
        .hor_y (hor_y),
        .dzk   (dzk),
        .flags (flags)
    );

    // Yaw angle and horizontal magnitude in parallel.
    pafp_cordic u_cordic_yaw (
        .aclk  (aclk),
        .en    (adv),
        .x_in  (yaw_x),
        .y_in  (yaw_y),
        .x_out (pitch_x_unused),
        .z_out (yaw_z)
    );

    pafp_cordic u_cordic_hor (
        .aclk  (aclk),
        .en    (adv),
        .x_in  (hor_x),
        .y_in  (hor_y),
        .x_out (hmag),
        .z_out ()
    );

    // Pitch from the horizontal magnitude and the gain-matched dz.
    pafp_cordic u_cordic_pitch (
        .aclk  (aclk),
        .en    (adv),
        .x_in  (hmag),
        .y_in  (dzk_dly_reg[CORDIC_STAGES-1]),
        .x_out (),
        .z_out (pitch_z)
    );

    // Valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LAT; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            valid_reg[0] <= accept;
            for (int i = 1; i < LAT; i++) begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // Side data that rides alongside the CORDIC passes.
    always_ff @(posedge aclk) begin
        if (adv) begin
            flags_dly_reg[0] <= flags;
            for (int i = 1; i < 2*CORDIC_STAGES; i++) begin
                flags_dly_reg[i] <= flags_dly_reg[i-1];
            end
            dzk_dly_reg[0]  <= dzk;
            yawz_dly_reg[0] <= yaw_z;
            for (int i = 1; i < CORDIC_STAGES; i++) begin
                dzk_dly_reg[i]  <= dzk_dly_reg[i-1];
                yawz_dly_reg[i] <= yawz_dly_reg[i-1];
            end
        end
    end

    // Final stage: offsets, special cases, rounding and clamping.
    always_comb begin
        fl       = flags_dly_reg[2*CORDIC_STAGES-1];
        yaw_a    = yawz_dly_reg[CORDIC_STAGES-1] + (fl.dx_pos ? DEG180_Q24 : ZW'(0));
        yaw_q8   = to_q8(yaw_a, -DEG90_Q8, DEG270_Q8);
        pitch_q8 = to_q8(pitch_z, -DEG90_Q8, DEG90_Q8);
        res_next.degen = fl.degen;
        priority if (fl.degen) begin
            res_next.yaw = '0;
            if (fl.dz_pos) begin
                res_next.pitch = PITCH_W'(DEG90_Q8);
            end else if (fl.dz_neg) begin
                res_next.pitch = PITCH_W'(-DEG90_Q8);
            end else begin
                res_next.pitch = '0;
            end
        end else if (fl.dx_zero) begin
            res_next.yaw   = fl.dy_pos ? YAW_W'(DEG270_Q8) : YAW_W'(DEG90_Q8);
            res_next.pitch = PITCH_W'(pitch_q8);
        end else begin
            res_next.yaw   = YAW_W'(yaw_q8);
            res_next.pitch = PITCH_W'(pitch_q8);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            res_reg <= res_next;
        end
    end

    pafp_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (adv && valid_reg[LAT-1]),
        .push_data (res_reg),
        .full      (full),
        .m_valid   (ob_valid),
        .m_ready   (m_tready),
        .m_data    (ob_data)
    );

    assign m_tvalid = ob_valid;
    assign m_tdata  = M_TDATA_W'({ob_data.yaw, ob_data.pitch});
    assign m_tuser  = ob_data.degen;

endmodule

FILE: rtl/pafp_checker.sv
// Port-level checks on the pointing-angle block, bound to its top level.
module pafp_checker import pafp_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser
);

    // A result that is not taken stays offered.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn before transfer");

    // Reset empties the output.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered after reset");

    // A degenerate result has zero yaw.
    a_degen_yaw: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[33:16] == 18'd0)
        else $error("degenerate result with nonzero yaw");

    // A degenerate result points straight up, straight down or nowhere.
    a_degen_pitch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |->
            m_tdata[15:0] == 16'h5A00 || m_tdata[15:0] == 16'hA600 ||
            m_tdata[15:0] == 16'h0000)
        else $error("degenerate result with bad pitch");

    // Yaw stays within -90 to 270 degrees.
    a_yaw_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $signed(m_tdata[33:16]) >= -18'sd23040 &&
            $signed(m_tdata[33:16]) <= 18'sd69120)
        else $error("yaw out of range");

endmodule

bind pointing_angles_from_points_top pafp_checker u_pafp_checker (.*);
